>>> hw/rtl/utf8d_pkg.sv
// utf8d_pkg: types and constants for the six-byte utf-8 stream decoder
// no dependencies; imported by every module of the decoder
package utf8d_pkg;

    localparam int unsigned CP_W  = 31;
    localparam int unsigned REM_W = 3;
    localparam int unsigned ST_W  = 2;

    // result status codes
    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_INVALID = 2'd1;
    localparam logic [ST_W-1:0] ST_TRUNC   = 2'd2;

    // lead byte thresholds
    localparam logic [7:0] LEAD_ILLEGAL = 8'hFE;
    localparam logic [7:0] LEAD_SIX     = 8'hFC;
    localparam logic [7:0] LEAD_FIVE    = 8'hF8;
    localparam logic [7:0] LEAD_FOUR    = 8'hF0;
    localparam logic [7:0] LEAD_THREE   = 8'hE0;
    localparam logic [7:0] LEAD_TWO     = 8'hC0;
    localparam logic [7:0] CONT_TAG     = 8'h80;
    localparam logic [7:0] CONT_MASK    = 8'hC0;
    localparam logic [7:0] PAYLOAD_MASK = 8'h3F;

    typedef struct packed {
        logic [REM_W-1:0] bytes_remaining;
        logic [CP_W-1:0]  accumulator;
    } t_dec_state;

    typedef struct packed {
        logic            emit;
        logic [CP_W-1:0] code_point;
        logic [ST_W-1:0] status;
    } t_dec_result;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       stream_end;
    } t_in_item;

endpackage

>>> hw/rtl/utf8d_in_stage.sv
// utf8d_in_stage: input register of the decoder with valid/stall handshake
// depends on utf8d_pkg
module utf8d_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  utf8d_pkg::t_in_item i_item,
    output logic                o_stall,
    input  logic                i_advance,
    output logic                o_valid,
    output utf8d_pkg::t_in_item o_item
);
    import utf8d_pkg::*;

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;
    logic     w_accept;

    assign o_stall  = r_valid && !i_advance;
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> hw/rtl/utf8d_step.sv
// utf8d_step: one decode step, from current state and byte to next state and result
// depends on utf8d_pkg
module utf8d_step (
    input  utf8d_pkg::t_in_item    i_item,
    input  utf8d_pkg::t_dec_state  i_state,
    output utf8d_pkg::t_dec_state  o_state,
    output utf8d_pkg::t_dec_result o_result
);
    import utf8d_pkg::*;

    logic [7:0]       w_b;
    logic [REM_W-1:0] w_extra;
    logic [5:0]       w_payload;
    logic [CP_W-1:0]  w_acc_shift;
    logic [REM_W-1:0] w_rem_dec;

    assign w_b         = i_item.byte_in;
    assign w_acc_shift = {i_state.accumulator[CP_W-7:0], w_b[5:0] & PAYLOAD_MASK[5:0]};
    assign w_rem_dec   = i_state.bytes_remaining - REM_W'(1);

    // lead byte: continuation count and high payload bits
    always_comb begin
        if (w_b >= LEAD_SIX) begin
            w_extra = REM_W'(5); w_payload = {5'd0, w_b[0]};
        end else if (w_b >= LEAD_FIVE) begin
            w_extra = REM_W'(4); w_payload = {4'd0, w_b[1:0]};
        end else if (w_b >= LEAD_FOUR) begin
            w_extra = REM_W'(3); w_payload = {3'd0, w_b[2:0]};
        end else if (w_b >= LEAD_THREE) begin
            w_extra = REM_W'(2); w_payload = {2'd0, w_b[3:0]};
        end else begin
            w_extra = REM_W'(1); w_payload = {1'b0, w_b[4:0]};
        end
    end

    always_comb begin
        o_state  = '0;
        o_result = '0;
        if (i_state.bytes_remaining == '0) begin
            if (!w_b[7]) begin
                o_result.emit       = 1'b1;
                o_result.code_point = CP_W'(w_b);
                o_result.status     = ST_OK;
            end else if (w_b >= LEAD_ILLEGAL || w_b < LEAD_TWO) begin
                o_result.emit   = 1'b1;
                o_result.status = ST_INVALID;
            end else if (i_item.stream_end) begin
                o_result.emit   = 1'b1;
                o_result.status = ST_TRUNC;
            end else begin
                o_state.bytes_remaining = w_extra;
                o_state.accumulator     = CP_W'(w_payload);
            end
        end else if ((w_b & CONT_MASK) != CONT_TAG) begin
            o_result.emit   = 1'b1;
            o_result.status = ST_INVALID;
        end else if (w_rem_dec == '0) begin
            o_result.emit       = 1'b1;
            o_result.code_point = w_acc_shift;
            o_result.status     = ST_OK;
        end else if (i_item.stream_end) begin
            o_result.emit   = 1'b1;
            o_result.status = ST_TRUNC;
        end else begin
            o_state.bytes_remaining = w_rem_dec;
            o_state.accumulator     = w_acc_shift;
        end
    end

endmodule

>>> hw/rtl/utf8_stream_decoder_31bit.sv
// utf8_stream_decoder_31bit: six-byte utf-8 byte stream to 31-bit code points
// each byte goes from the input register through the step to the result register
// throughput: one byte per cycle while results are not stalled, as the combinational
//   step lies between the input register and the result register
// reset: synchronous active-low i_rst_n empties both registers and returns to idle
module utf8_stream_decoder_31bit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // byte input channel
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [7:0]                i_byte_in,
    input  logic                      i_stream_end,
    // code point output channel
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [utf8d_pkg::CP_W-1:0] o_code_point,
    output logic [utf8d_pkg::ST_W-1:0] o_status
);
    import utf8d_pkg::*;

    t_in_item    w_in_item;
    t_in_item    w_cur_item;
    logic        w_cur_valid;
    logic        w_advance;
    logic        w_step;
    t_dec_state  r_state;
    t_dec_state  n_state;
    t_dec_result w_result;
    logic        r_out_valid;
    logic        n_out_valid;
    logic [CP_W-1:0] r_code_point;
    logic [ST_W-1:0] r_status;

    assign w_in_item.byte_in    = i_byte_in;
    assign w_in_item.stream_end = i_stream_end;

    // the output register can take a new result when empty or being drained
    assign w_advance = !r_out_valid || !i_stall;
    assign w_step    = w_cur_valid && w_advance;

    utf8d_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_item    (w_in_item),
        .o_stall   (o_stall),
        .i_advance (w_advance),
        .o_valid   (w_cur_valid),
        .o_item    (w_cur_item)
    );

    // sequence decode for the byte in the input register
    utf8d_step u_step (
        .i_item   (w_cur_item),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (w_result)
    );

    // decoder state moves only when the held byte is consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_step) begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_step && w_result.emit) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // result payload, held while the output transaction is stalled
    always_ff @(posedge i_clk) begin
        if (w_step && w_result.emit) begin
            r_code_point <= w_result.code_point;
            r_status     <= w_result.status;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_code_point = r_code_point;
    assign o_status     = r_status;

endmodule

>>> tb/utf8d_scoreboard_pkg.sv
// scoreboard for the utf-8 stream decoder: a byte-level decode predictor and
// the queue of code points it expects, checked in order against the results
// depends on utf8d_pkg for widths and status codes
`timescale 1ns / 1ps

package utf8d_scoreboard_pkg;

    import utf8d_pkg::*;

    typedef struct {
        logic [CP_W-1:0] code_point;
        logic [ST_W-1:0] status;
    } t_decoded_char;

    class utf8_char_scoreboard;

        logic [REM_W-1:0] conts_left;
        logic [CP_W-1:0]  partial_cp;
        t_decoded_char    expected_chars[$];
        int unsigned      mismatches;
        int unsigned      bytes_seen;
        int unsigned      ok_count;
        int unsigned      invalid_count;
        int unsigned      trunc_count;

        function new();
            conts_left    = '0;
            partial_cp    = '0;
            mismatches    = 0;
            bytes_seen    = 0;
            ok_count      = 0;
            invalid_count = 0;
            trunc_count   = 0;
        endfunction

        function void push_char(logic [CP_W-1:0] cp, logic [ST_W-1:0] st);
            t_decoded_char c;
            c.code_point = cp;
            c.status     = st;
            // append at the tail
            expected_chars.insert(expected_chars.size(), c);
        endfunction

        function void back_to_idle();
            conts_left = '0;
            partial_cp = '0;
        endfunction

        // decode one accepted byte and queue the character it completes, if any
        function void note_byte(logic [7:0] b, logic last);
            logic [REM_W-1:0] extra;
            logic [CP_W-1:0]  lead_bits;
            bytes_seen++;
            if (conts_left == '0) begin
                if (b < CONT_TAG) begin
                    push_char(CP_W'(b), ST_OK);
                end else if (b >= LEAD_ILLEGAL || b < LEAD_TWO) begin
                    push_char('0, ST_INVALID);
                end else begin
                    if (b >= LEAD_SIX) begin
                        extra = 3'd5; lead_bits = CP_W'(b[0]);
                    end else if (b >= LEAD_FIVE) begin
                        extra = 3'd4; lead_bits = CP_W'(b[1:0]);
                    end else if (b >= LEAD_FOUR) begin
                        extra = 3'd3; lead_bits = CP_W'(b[2:0]);
                    end else if (b >= LEAD_THREE) begin
                        extra = 3'd2; lead_bits = CP_W'(b[3:0]);
                    end else begin
                        extra = 3'd1; lead_bits = CP_W'(b[4:0]);
                    end
                    if (last) begin
                        back_to_idle();
                        push_char('0, ST_TRUNC);
                    end else begin
                        conts_left = extra;
                        partial_cp = lead_bits;
                    end
                end
            end else if ((b & CONT_MASK) != CONT_TAG) begin
                // bad continuation is dropped, not reused as a lead
                back_to_idle();
                push_char('0, ST_INVALID);
            end else begin
                partial_cp = {partial_cp[CP_W-7:0], b[5:0]};
                conts_left = conts_left - 3'd1;
                if (conts_left == '0) begin
                    push_char(partial_cp, ST_OK);
                    back_to_idle();
                end else if (last) begin
                    back_to_idle();
                    push_char('0, ST_TRUNC);
                end
            end
        endfunction

        function void check_char(logic [CP_W-1:0] cp, logic [ST_W-1:0] st);
            t_decoded_char want;
            if (expected_chars.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: code_point 0x%08h status %0d", cp, st);
                return;
            end
            want = expected_chars.pop_front();
            case (st)
                ST_OK:      ok_count++;
                ST_INVALID: invalid_count++;
                ST_TRUNC:   trunc_count++;
                default:    ;
            endcase
            if (cp !== want.code_point || st !== want.status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected code_point 0x%08h status %0d, got 0x%08h %0d",
                             want.code_point, want.status, cp, st);
            end
        endfunction

        function int unsigned waiting();
            return expected_chars.size();
        endfunction

    endclass

endpackage

>>> tb/tb_top.sv
// top-level testbench for utf8_stream_decoder_31bit: directed and random
// byte streams with random idle and stall on both channels
// depends on utf8d_pkg and utf8d_scoreboard_pkg
`timescale 1ns / 1ps

module tb_top;

    import utf8d_pkg::*;
    import utf8d_scoreboard_pkg::*;

    // run shape
    localparam int unsigned RANDOM_BYTES  = 950;
    localparam int unsigned IDLE_PCT      = 26;
    localparam int unsigned HOLD_AT       = 200;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned STEADY_FROM   = 350;
    localparam int unsigned STEADY_TO     = 550;
    localparam int unsigned DRAIN_CYCLES  = 20;
    localparam int unsigned QUIET_LIMIT   = 2000;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [7:0]          i_byte_in;
    logic                i_stream_end;
    logic                o_valid;
    logic                i_stall;
    logic [CP_W-1:0]     o_code_point;
    logic [ST_W-1:0]     o_status;

    utf8_char_scoreboard sb;
    int unsigned         sent_count;
    int unsigned         quiet_cycles;
    bit                  steady_run;
    bit                  hold_done;

    utf8_stream_decoder_31bit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_byte_in    (i_byte_in),
        .i_stream_end (i_stream_end),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_code_point (o_code_point),
        .o_status     (o_status)
    );

    // 12 ns clock
    always #6 i_clk = ~i_clk;

    // offer one byte transaction, with random idle cycles in front of it,
    // and hold it until the decoder takes it
    task automatic send_byte(input logic [7:0] b, input logic last);
        steady_run = (sent_count >= STEADY_FROM && sent_count < STEADY_TO);
        while (!steady_run && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_byte_in    <= b;
        i_stream_end <= last;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        // accepted at this edge
        sb.note_byte(b, last);
        sent_count++;
    endtask

    // continuation byte with random payload
    function automatic logic [7:0] cont_byte();
        return CONT_TAG | 8'($urandom_range(0, 63));
    endfunction

    // lead byte for a character of the given length, 1 to 6 bytes
    function automatic logic [7:0] lead_byte(input int unsigned len);
        case (len)
            1:       return 8'($urandom_range(8'h00, 8'h7F));
            2:       return 8'($urandom_range(8'hC0, 8'hDF));
            3:       return 8'($urandom_range(8'hE0, 8'hEF));
            4:       return 8'($urandom_range(8'hF0, 8'hF7));
            5:       return 8'($urandom_range(8'hF8, 8'hFB));
            default: return 8'($urandom_range(8'hFC, 8'hFD));
        endcase
    endfunction

    // one random chunk of the stream: mostly well-formed characters,
    // some broken by a bad continuation, some plain noise bytes
    task automatic send_random_chunk();
        int unsigned kind;
        int unsigned len;
        int unsigned cut;
        logic [7:0]  bad;
        kind = $urandom_range(99);
        if (kind < 70) begin
            len = $urandom_range(1, 6);
            // now and then the buffer ends part way through the character
            if (len > 1 && $urandom_range(99) < 8)
                cut = $urandom_range(0, len - 2);
            else
                cut = len;
            for (int unsigned i = 0; i < len && i <= cut; i++) begin
                if (i == cut)
                    send_byte(i == 0 ? lead_byte(len) : cont_byte(), 1'b1);
                else if (i == 0)
                    send_byte(lead_byte(len),
                              len == 1 && $urandom_range(99) < 10);
                else
                    send_byte(cont_byte(), i == len - 1 && $urandom_range(99) < 10);
            end
        end else if (kind < 85) begin
            len = $urandom_range(2, 6);
            cut = $urandom_range(1, len - 1);
            send_byte(lead_byte(len), 1'b0);
            for (int unsigned i = 1; i < cut; i++)
                send_byte(cont_byte(), 1'b0);
            // anything whose top two bits are not 10
            do bad = 8'($urandom_range(0, 255)); while ((bad & CONT_MASK) == CONT_TAG);
            send_byte(bad, $urandom_range(99) < 25);
        end else begin
            send_byte(8'($urandom_range(0, 255)), $urandom_range(99) < 20);
        end
    endtask

    // result side: random stall, one long hold-off so the decoder backs up
    initial begin
        i_stall   <= 1'b0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0)
                sb.check_char(o_code_point, o_status);
            if (!hold_done && sent_count >= HOLD_AT) begin
                hold_done = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_stall <= !steady_run && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout after %0d quiet cycles", quiet_cycles);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // stimulus and end of run
    initial begin
        sb           = new();
        sent_count   = 0;
        quiet_cycles = 0;
        steady_run   = 1'b0;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_byte_in    <= 8'h00;
        i_stream_end <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // plain bytes at both ends of the ascii range
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
        // stray continuations and illegal leads while idle
        send_byte(8'h80, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'hFF, 1'b1);
        // lead byte that is also the last byte of the buffer
        send_byte(8'hC3, 1'b1);
        // smallest two-byte form, overlong but accepted
        send_byte(8'hC0, 1'b0);
        send_byte(8'h80, 1'b0);
        // largest six-byte form, full 31-bit code point
        send_byte(8'hFD, 1'b0);
        repeat (5) send_byte(8'hBF, 1'b0);
        // bad continuation with a plain byte
        send_byte(8'hE0, 1'b0);
        send_byte(8'h41, 1'b0);
        // bad continuation that looks like a lead, on the last byte:
        // invalid beats truncated, and the byte is not taken as a lead
        send_byte(8'hC2, 1'b0);
        send_byte(8'hE0, 1'b1);
        send_byte(8'h41, 1'b0);
        // buffer ends in the middle of a four-byte character
        send_byte(8'hF0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b1);
        // buffer ends right on a complete character
        send_byte(8'hDF, 1'b0);
        send_byte(8'hBF, 1'b1);

        while (sent_count < RANDOM_BYTES)
            send_random_chunk();
        i_valid <= 1'b0;

        // drain, then give the pipeline time to show any stray result
        while (sb.waiting() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d bytes sent, %0d code points, %0d invalid, %0d truncated checked",
                 sb.bytes_seen, sb.ok_count, sb.invalid_count, sb.trunc_count);
        $display("%0d mismatches", sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
